[rtl/core/srgemv_pkg.sv]
package srgemv_pkg;

  // vector store geometry
  localparam int VEC_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(VEC_DEPTH);

  // field widths
  localparam int COL_W   = 12;
  localparam int DATA_W  = 32;
  localparam int ROW_W   = 16;
  localparam int PADDR_W = 3;
  localparam int FRAC_W  = 16;

  // item commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_NONZERO = 2'd2;

  // register select (paddr bit 2)
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  typedef logic signed [DATA_W-1:0]   q_t;
  typedef logic signed [2*DATA_W-1:0] prod_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic p1_en;
    logic beta_sel;
    logic t_en;
    logic p2_en;
    logic seed_sel;
    logic acc_en;
    logic emit;
  } dp_ctrl_t;

  // q16.16 product: floor shift by the fraction width, then saturate
  function automatic q_t q_trunc(input prod_t p);
    logic signed [2*DATA_W-FRAC_W-1:0] s;
    logic                              fits;
    begin
      s    = p[2*DATA_W-1:FRAC_W];
      fits = (&s[2*DATA_W-FRAC_W-1:DATA_W-1]) || !(|s[2*DATA_W-FRAC_W-1:DATA_W-1]);
      if (fits) begin
        q_trunc = s[DATA_W-1:0];
      end else if (s[2*DATA_W-FRAC_W-1]) begin
        q_trunc = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        q_trunc = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  endfunction

  // saturating add
  function automatic q_t q_add(input q_t a, input q_t b);
    logic signed [DATA_W:0] sum;
    begin
      sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (sum[DATA_W] == sum[DATA_W-1]) begin
        q_add = sum[DATA_W-1:0];
      end else if (sum[DATA_W]) begin
        q_add = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        q_add = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

[rtl/core/sparse_row_gemv.sv]
// an x load is written into the store with its transaction; a row result is
// registered from the final state (MUL1 for a start, ADD after MUL1 and MUL2
// for a nonzero) and is held back by any output stall; loads are taken 1 per
// cycle while idle, and a start or nonzero keeps the input closed until done
// reset (synchronous, active high) clears sequencer, output valid,
// accumulator, row counter and beta gain, sets alpha gain to 1.0; x store kept
module sparse_row_gemv (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       command,
  input  logic [srgemv_pkg::COL_W-1:0]     column_index,
  input  logic signed [srgemv_pkg::DATA_W-1:0] operand_value,
  input  logic                             row_end,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [srgemv_pkg::ROW_W-1:0]     row_number,
  output logic signed [srgemv_pkg::DATA_W-1:0] result_value,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srgemv_pkg::PADDR_W-1:0]   paddr,
  input  logic [srgemv_pkg::DATA_W-1:0]    pwdata,
  output logic [srgemv_pkg::DATA_W-1:0]    prdata,
  output logic                             pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_ADD  = 2'd3;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic                           accept;
  logic                           col_in_range;
  logic                           cur_nz;
  logic                           cur_last;
  logic                           col_ok;
  logic                           final_stage;
  logic                           blocked;
  logic                           mem_en;
  logic                           mem_we;
  logic [srgemv_pkg::DATA_W-1:0]  mem_rdata;
  srgemv_pkg::q_t                 x_data;
  srgemv_pkg::q_t                 alpha_gain;
  srgemv_pkg::q_t                 beta_gain;
  srgemv_pkg::q_t                 acc_new;
  logic [srgemv_pkg::ROW_W-1:0]   row_counter;
  srgemv_pkg::dp_ctrl_t           ctrl;

  srgemv_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .alpha_gain (alpha_gain),
    .beta_gain  (beta_gain)
  );

  // one item in flight
  assign item_stall   = (state != ST_IDLE);
  assign accept       = item_valid && !item_stall;
  assign col_in_range = (32'(column_index) < srgemv_pkg::VEC_DEPTH);

  // x store access: writes for loads, reads for nonzeros
  assign mem_we = (command == srgemv_pkg::CMD_LOAD);
  assign mem_en = accept && ((mem_we && col_in_range) ||
                             (command == srgemv_pkg::CMD_NONZERO));

  srgemv_xmem u_xmem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (srgemv_pkg::ADDR_W'(column_index)),
    .wdata (operand_value),
    .rdata (mem_rdata)
  );

  assign x_data = col_ok ? mem_rdata : '0;

  // item attributes held while it works
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_nz   <= (command == srgemv_pkg::CMD_NONZERO);
      cur_last <= row_end;
      col_ok   <= col_in_range;
    end
  end

  // result waits when the output register is still occupied
  assign final_stage = ((state == ST_MUL1) && !cur_nz) || (state == ST_ADD);
  assign blocked     = cur_last && result_valid && result_stall;

  always_comb begin
    ctrl.p1_en    = accept && ((command == srgemv_pkg::CMD_START) ||
                               (command == srgemv_pkg::CMD_NONZERO));
    ctrl.beta_sel = (command == srgemv_pkg::CMD_START);
    ctrl.t_en     = (state == ST_MUL1) && cur_nz;
    ctrl.p2_en    = (state == ST_MUL2);
    ctrl.seed_sel = (state == ST_MUL1);
    ctrl.acc_en   = final_stage && !blocked;
    ctrl.emit     = final_stage && !blocked && cur_last;
  end

  srgemv_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .alpha_gain    (alpha_gain),
    .beta_gain     (beta_gain),
    .operand_value (operand_value),
    .x_data        (x_data),
    .acc_new       (acc_new),
    .row_counter   (row_counter)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctrl.p1_en) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (cur_nz) begin
          state_next = ST_MUL2;
        end else if (!blocked) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL2: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        if (!blocked) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      row_number   <= row_counter;
      result_value <= acc_new;
    end
  end

endmodule

[rtl/core/srgemv_cfg.sv]
module srgemv_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srgemv_pkg::PADDR_W-1:0]   paddr,
  input  logic [srgemv_pkg::DATA_W-1:0]    pwdata,
  output logic [srgemv_pkg::DATA_W-1:0]    prdata,
  output logic                             pready,
  output srgemv_pkg::q_t                   alpha_gain,
  output srgemv_pkg::q_t                   beta_gain
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= srgemv_pkg::q_t'(65536);
      beta_gain  <= '0;
    end else if (wr_en) begin
      if (paddr[2] == srgemv_pkg::REG_BETA) begin
        beta_gain <= pwdata;
      end else begin
        alpha_gain <= pwdata;
      end
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == srgemv_pkg::REG_BETA) begin
      prdata = beta_gain;
    end else begin
      prdata = alpha_gain;
    end
  end

endmodule

[rtl/core/srgemv_xmem.sv]
module srgemv_xmem (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            we,
  input  logic [srgemv_pkg::ADDR_W-1:0]   addr,
  input  logic [srgemv_pkg::DATA_W-1:0]   wdata,
  output logic [srgemv_pkg::DATA_W-1:0]   rdata
);

  logic [srgemv_pkg::DATA_W-1:0] mem [srgemv_pkg::VEC_DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/core/srgemv_datapath.sv]
module srgemv_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  srgemv_pkg::dp_ctrl_t           ctrl,
  input  srgemv_pkg::q_t                 alpha_gain,
  input  srgemv_pkg::q_t                 beta_gain,
  input  srgemv_pkg::q_t                 operand_value,
  input  srgemv_pkg::q_t                 x_data,
  output srgemv_pkg::q_t                 acc_new,
  output logic [srgemv_pkg::ROW_W-1:0]   row_counter
);

  srgemv_pkg::q_t    gain;
  srgemv_pkg::prod_t p1;
  srgemv_pkg::prod_t p2;
  srgemv_pkg::q_t    t;
  srgemv_pkg::q_t    acc;

  assign gain = ctrl.beta_sel ? beta_gain : alpha_gain;

  // first product: gain times operand, taken with the transaction
  always_ff @(posedge clk) begin
    if (ctrl.p1_en) begin
      p1 <= srgemv_pkg::prod_t'(gain) * srgemv_pkg::prod_t'(operand_value);
    end
  end

  // scaled value, then product with the x entry
  always_ff @(posedge clk) begin
    if (ctrl.t_en) begin
      t <= srgemv_pkg::q_trunc(p1);
    end
    if (ctrl.p2_en) begin
      p2 <= srgemv_pkg::prod_t'(t) * srgemv_pkg::prod_t'(x_data);
    end
  end

  // seed or saturating accumulate
  assign acc_new = ctrl.seed_sel ? srgemv_pkg::q_trunc(p1)
                                 : srgemv_pkg::q_add(acc, srgemv_pkg::q_trunc(p2));

  // accumulator and row count
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      row_counter <= '0;
    end else if (ctrl.acc_en) begin
      if (ctrl.emit) begin
        acc         <= '0;
        row_counter <= row_counter + 1'b1;
      end else begin
        acc <= acc_new;
      end
    end
  end

endmodule

[rtl/core/srgemv_checker.sv]
module srgemv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_stall,
  input logic [1:0]                       command,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [srgemv_pkg::ROW_W-1:0]     row_number,
  input logic [srgemv_pkg::DATA_W-1:0]    result_value
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(row_number) &&
                                     $stable(result_value))
    else $error("stalled result changed");

  // loads never hold up the next transaction
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command == srgemv_pkg::CMD_LOAD) |=> !item_stall)
    else $error("load occupied the block");

  // a nonzero keeps the input closed through both multiplies and the add
  a_nz_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command == srgemv_pkg::CMD_NONZERO) |=>
      item_stall ##1 item_stall ##1 item_stall)
    else $error("nonzero finished too early");

  // reset leaves no result and an open input
  a_reset_state: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("bad state after reset");

endmodule

bind sparse_row_gemv srgemv_checker u_srgemv_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .command      (command),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .row_number   (row_number),
  .result_value (result_value)
);
